[design/wgma_pkg.sv]
// Shared constants, types and arithmetic helpers for the weighted Gram accumulator.
package wgma_pkg;

    localparam int MAX_FUNCTIONS = 8;
    localparam int IDX_W         = $clog2(MAX_FUNCTIONS);
    localparam int ADDR_W        = 2 * IDX_W;
    localparam int DEPTH         = MAX_FUNCTIONS * MAX_FUNCTIONS;
    localparam int CNT_W         = 4;
    localparam int WEIGHT_W      = 24;
    localparam int VALUE_W       = 16;
    localparam int PROD_W        = 2 * VALUE_W;
    localparam int TERM_W        = PROD_W + WEIGHT_W + 1;
    localparam int SUM_W         = 64;

    localparam logic [CNT_W-1:0] NUM_FUNCTIONS_RESET = CNT_W'(MAX_FUNCTIONS);

    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic signed [SUM_W-1:0]   sum_t;
    typedef logic        [IDX_W-1:0]   idx_t;
    typedef logic        [ADDR_W-1:0]  addr_t;

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_ACC      = 6'b000010,
        ST_DRAIN    = 6'b000100,
        ST_EMIT_RD  = 6'b001000,
        ST_EMIT_LD  = 6'b010000,
        ST_EMIT_OUT = 6'b100000
    } state_t;

    // Index of the last function in use; zero acts as one, large counts clamp.
    function automatic idx_t last_index(input logic [CNT_W-1:0] n);
        idx_t r;
        if (n == '0)
            r = '0;
        else if (n > CNT_W'(MAX_FUNCTIONS))
            r = IDX_W'(MAX_FUNCTIONS - 1);
        else
            r = IDX_W'(n - CNT_W'(1));
        return r;
    endfunction

    function automatic sum_t sat_add(input sum_t a, input sum_t b);
        sum_t s;
        sum_t r;
        s = a + b;
        if (a[SUM_W-1] == b[SUM_W-1] && s[SUM_W-1] != a[SUM_W-1])
            r = a[SUM_W-1] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        else
            r = s;
        return r;
    endfunction

endpackage

[design/wgma_ifs.sv]
// Stream interfaces for mesh points in and matrix entries out.
interface wgma_point_if;
    import wgma_pkg::*;

    logic                valid;
    logic                ready;
    logic [WEIGHT_W-1:0] weight;
    value_t              value0;
    value_t              value1;
    value_t              value2;
    value_t              value3;
    value_t              value4;
    value_t              value5;
    value_t              value6;
    value_t              value7;
    logic                last_point;

    modport source (
        output valid, weight, value0, value1, value2, value3,
               value4, value5, value6, value7, last_point,
        input  ready
    );
    modport sink (
        input  valid, weight, value0, value1, value2, value3,
               value4, value5, value6, value7, last_point,
        output ready
    );
endinterface

interface wgma_entry_if;
    import wgma_pkg::*;

    logic   valid;
    logic   ready;
    idx_t   row;
    idx_t   col;
    sum_t   sum;
    logic   last_entry;

    modport source (
        output valid, row, col, sum, last_entry,
        input  ready
    );
    modport sink (
        input  valid, row, col, sum, last_entry,
        output ready
    );
endinterface

[design/weighted_gram_matrix_accumulator_core.sv]
// Weighted Gram matrix accumulator: top level with RMW pipeline and entry readout.
// For each mesh point, one store read-modify-write is issued per cycle over the
// upper triangle, then the pipeline drains.
// On a last point, each used entry then passes EMIT_RD, EMIT_LD and EMIT_OUT, waiting there until taken.
// Reset (rst_n low, async) clears all control state and per-entry valid bits,
// so every accumulator reads as zero; num_functions resets to 8. No clearing pass.
module weighted_gram_matrix_accumulator_core (
    input  logic                      clk,
    input  logic                      rst_n,
    wgma_point_if.sink                points,
    wgma_entry_if.source              entries,
    input  logic                      cfg_we,
    input  logic [wgma_pkg::CNT_W-1:0] cfg_wdata
);
    import wgma_pkg::*;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    num_functions_reg;

    idx_t                i_reg, i_next;
    idx_t                j_reg, j_next;
    idx_t                last_idx_reg;
    logic                last_point_reg;
    logic [WEIGHT_W-1:0] weight_reg;
    value_t              rowbuf_reg [MAX_FUNCTIONS];
    value_t              colbuf_reg [MAX_FUNCTIONS];
    value_t              vals_in    [MAX_FUNCTIONS];

    logic [DEPTH-1:0]    entry_valid_reg;
    logic                rd_valid_reg;

    logic                s1_valid_reg;
    addr_t               s1_addr_reg;
    logic signed [PROD_W-1:0] s1_prod_reg;

    logic                s2_valid_reg;
    addr_t               s2_addr_reg;
    logic signed [TERM_W-1:0] s2_term_reg;
    sum_t                s2_old_reg;

    addr_t               rd_addr;
    sum_t                rd_data;
    sum_t                wr_data;

    idx_t                row_reg;
    idx_t                col_reg;
    sum_t                sum_reg;
    logic                last_entry_reg;

    logic                accept;
    logic                out_xfer;
    logic                pair_last;
    logic                row_end;

    assign vals_in[0] = points.value0;
    assign vals_in[1] = points.value1;
    assign vals_in[2] = points.value2;
    assign vals_in[3] = points.value3;
    assign vals_in[4] = points.value4;
    assign vals_in[5] = points.value5;
    assign vals_in[6] = points.value6;
    assign vals_in[7] = points.value7;

    assign points.ready = (state_reg == ST_IDLE);
    assign accept       = points.valid && points.ready;

    assign entries.valid      = (state_reg == ST_EMIT_OUT);
    assign entries.row        = row_reg;
    assign entries.col        = col_reg;
    assign entries.sum        = sum_reg;
    assign entries.last_entry = last_entry_reg;
    assign out_xfer           = entries.valid && entries.ready;

    assign row_end   = (j_reg == last_idx_reg);
    assign pair_last = row_end && (i_reg == last_idx_reg);

    assign rd_addr = {i_reg, j_reg};
    assign wr_data = sat_add(s2_old_reg, SUM_W'(s2_term_reg));

    wgma_ram #(
        .WIDTH(SUM_W),
        .DEPTH(DEPTH)
    ) u_store (
        .clk  (clk),
        .we   (s2_valid_reg),
        .waddr(s2_addr_reg),
        .wdata(wr_data),
        .raddr(rd_addr),
        .rdata(rd_data)
    );

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_ACC;
                    i_next     = '0;
                    j_next     = '0;
                end
            end
            ST_ACC:
            begin
                if (pair_last)
                begin
                    state_next = ST_DRAIN;
                end
                else if (row_end)
                begin
                    i_next = i_reg + IDX_W'(1);
                    j_next = i_reg + IDX_W'(1);
                end
                else
                begin
                    j_next = j_reg + IDX_W'(1);
                end
            end
            ST_DRAIN:
            begin
                if (!s1_valid_reg && !s2_valid_reg)
                begin
                    i_next     = '0;
                    j_next     = '0;
                    state_next = last_point_reg ? ST_EMIT_RD : ST_IDLE;
                end
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD:
            begin
                state_next = ST_EMIT_OUT;
            end
            ST_EMIT_OUT:
            begin
                if (out_xfer)
                begin
                    if (pair_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_EMIT_RD;
                        if (row_end)
                        begin
                            i_next = i_reg + IDX_W'(1);
                            j_next = i_reg + IDX_W'(1);
                        end
                        else
                        begin
                            j_next = j_reg + IDX_W'(1);
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            num_functions_reg <= NUM_FUNCTIONS_RESET;
            i_reg             <= '0;
            j_reg             <= '0;
            s1_valid_reg      <= 1'b0;
            s2_valid_reg      <= 1'b0;
            entry_valid_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            i_reg        <= i_next;
            j_reg        <= j_next;
            s1_valid_reg <= (state_reg == ST_ACC);
            s2_valid_reg <= s1_valid_reg;
            if (cfg_we)
            begin
                num_functions_reg <= cfg_wdata;
            end
            if (state_reg == ST_EMIT_OUT && out_xfer && pair_last)
            begin
                entry_valid_reg <= '0;
            end
            else if (s2_valid_reg)
            begin
                entry_valid_reg[s2_addr_reg] <= 1'b1;
            end
        end
    end

    // Datapath registers, no reset needed.
    always_ff @(posedge clk)
    begin
        rd_valid_reg <= entry_valid_reg[rd_addr];

        if (accept)
        begin
            weight_reg     <= points.weight;
            last_point_reg <= points.last_point;
            last_idx_reg   <= last_index(num_functions_reg);
            for (int k = 0; k < MAX_FUNCTIONS; k++)
            begin
                rowbuf_reg[k] <= vals_in[k];
                colbuf_reg[k] <= vals_in[k];
            end
        end
        else if (state_reg == ST_ACC && !pair_last)
        begin
            // Column taps walk right; a new row restarts them at the diagonal.
            for (int k = 0; k < MAX_FUNCTIONS - 1; k++)
            begin
                colbuf_reg[k] <= row_end ? rowbuf_reg[k+1] : colbuf_reg[k+1];
                if (row_end)
                begin
                    rowbuf_reg[k] <= rowbuf_reg[k+1];
                end
            end
            colbuf_reg[MAX_FUNCTIONS-1] <= '0;
            if (row_end)
            begin
                rowbuf_reg[MAX_FUNCTIONS-1] <= '0;
            end
        end

        s1_addr_reg <= rd_addr;
        s1_prod_reg <= rowbuf_reg[0] * colbuf_reg[0];

        s2_addr_reg <= s1_addr_reg;
        s2_term_reg <= s1_prod_reg * $signed({1'b0, weight_reg});
        s2_old_reg  <= rd_valid_reg ? rd_data : '0;

        if (state_reg == ST_EMIT_LD)
        begin
            row_reg        <= i_reg;
            col_reg        <= j_reg;
            sum_reg        <= rd_valid_reg ? rd_data : '0;
            last_entry_reg <= pair_last;
        end
    end

endmodule

[design/wgma_ram.sv]
// Generic simple dual-port RAM, one write and one registered read port.
module wgma_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
